>>> rtl/core/lottery_task_scheduler_defines.svh
// Assertion helpers for the lottery scheduler.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef LOTTERY_TASK_SCHEDULER_DEFINES_SVH
`define LOTTERY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define LTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lts_pkg.sv
package lts_pkg;

  // request kinds (in_tuser)
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  // configuration register indexes
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic REG_ACTIVE  = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int QUANTUM_W  = 16;
  localparam int ACTIVE_W   = 5;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd1;

  // field widths
  localparam int SLOT_FW    = 4;
  localparam int RUNTIME_FW = 16;
  localparam int TICKET_FW  = 16;
  localparam int TOTAL_W    = 20;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

endpackage

>>> rtl/core/lottery_task_scheduler.sv
// Lottery task scheduler.
// Input stream (in_*): one request per transfer. in_tuser = 0 loads a task slot
// (slot, runtime, tickets); in_tuser = 1 is a draw carrying a random ticket number.
// Output stream (out_*): exactly one result per request, in request order.
// Configuration: cfg_we/cfg_index/cfg_wdata write quantum (0) and active task count (1);
// write only while no request is in flight.
// Slot state lives in one synchronous RAM of runtime/ticket pairs plus a valid bit
// per slot; reset clears the valid bits, the ticket total and config (quantum 1,
// active 0), so all slots read as empty at once.
// From accept to out_tvalid, a load does a RAM read, write-back and output load.
// A draw scans the RAM one slot per cycle over the n active slots (n capped at
// MAX_TASKS); when a slot wins it goes on to write-back and output load, when
// none wins straight to output load, and with no active slots it skips the scan.
// One request is worked on at a time; in_tready is high while the engine is idle,
// which it is again as soon as the result enters the output register.
// The output register holds a result until out_tready; the next request may be
// accepted while it waits, and its result is held back until the register frees.
`include "lottery_task_scheduler_defines.svh"

module lottery_task_scheduler #(
  parameter int MAX_TASKS    = 16,
  parameter int RUNTIME_BITS = 16,
  parameter int TICKET_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // task_slot[3:0], task_runtime[19:4], task_tickets[35:20], drawn_ticket[55:36]
  input  logic [lts_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // winner_slot[3:0], left_runtime[19:4], task_finished[20], all_done[21],
  // tickets_left[41:22], zero fill above
  output logic [lts_pkg::OUT_DATA_W-1:0]  out_tdata,
  // winner_found[0]
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SLOT_W  = $clog2(MAX_TASKS);
  localparam int ENT_W   = RUNTIME_BITS + TICKET_BITS;
  localparam int RUN_W   = TICKET_BITS + SLOT_W + 1;
  localparam int CW      = (RUN_W > lts_pkg::TOTAL_W) ? RUN_W : lts_pkg::TOTAL_W;
  localparam int QW      = (RUNTIME_BITS > lts_pkg::QUANTUM_W) ? RUNTIME_BITS
                                                               : lts_pkg::QUANTUM_W;
  localparam int LIM_W   = (SLOT_W + 1 > lts_pkg::ACTIVE_W) ? SLOT_W + 1
                                                            : lts_pkg::ACTIVE_W;
  localparam int SLOT_IN_RANGE = 1 << lts_pkg::SLOT_FW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TASKS - 1);

  // input fields
  logic [lts_pkg::SLOT_FW-1:0]    in_slot;
  logic [lts_pkg::RUNTIME_FW-1:0] in_rt;
  logic [lts_pkg::TICKET_FW-1:0]  in_tk;
  logic [lts_pkg::TOTAL_W-1:0]    in_draw;

  assign in_slot = in_tdata[3:0];
  assign in_rt   = in_tdata[19:4];
  assign in_tk   = in_tdata[35:20];
  assign in_draw = in_tdata[55:36];

  logic [2:0]                      state_r, state_nxt;
  logic [lts_pkg::QUANTUM_W-1:0]   quantum_r;
  logic [lts_pkg::ACTIVE_W-1:0]    active_r;
  logic [lts_pkg::TOTAL_W-1:0]     total_r, total_nxt;

  logic [SLOT_W-1:0]               ld_slot_r, ld_slot_nxt;
  logic [RUNTIME_BITS-1:0]         ld_rt_r, ld_rt_nxt;
  logic [TICKET_BITS-1:0]          ld_tk_r, ld_tk_nxt;
  logic [lts_pkg::TOTAL_W-1:0]     draw_r, draw_nxt;
  logic [SLOT_W-1:0]               last_r, last_nxt;
  logic [SLOT_W-1:0]               scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0]               chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]                   run_r, run_nxt;
  logic [RUNTIME_BITS-1:0]         win_rt_r, win_rt_nxt;
  logic [TICKET_BITS-1:0]          win_tk_r, win_tk_nxt;
  logic [SLOT_W-1:0]               win_slot_r, win_slot_nxt;

  logic                            res_found_r, res_found_nxt;
  logic [lts_pkg::SLOT_FW-1:0]     res_slot_r, res_slot_nxt;
  logic [lts_pkg::RUNTIME_FW-1:0]  res_left_r, res_left_nxt;
  logic                            res_fin_r, res_fin_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [lts_pkg::OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                            out_user_r, out_user_nxt;

  // slot RAM: {runtime, tickets}
  logic [ENT_W-1:0]                mem [MAX_TASKS];
  logic [MAX_TASKS-1:0]            vld_r;
  logic [ENT_W-1:0]                rd_data_r;
  logic                            rd_vld_r;
  logic [SLOT_W-1:0]               rd_addr;
  logic                            mem_we;
  logic [SLOT_W-1:0]               mem_wa;
  logic [ENT_W-1:0]                mem_wd;

  logic [RUNTIME_BITS-1:0]         rd_rt;
  logic [TICKET_BITS-1:0]          rd_tk;
  logic [CW-1:0]                   run_sum;
  logic                            hit;

  logic [SLOT_W-1:0]               slot_mod;
  logic [RUNTIME_BITS-1:0]         load_rt;
  logic [TICKET_BITS-1:0]          load_tk;
  logic [LIM_W-1:0]                act_ext;
  logic [SLOT_W-1:0]               act_last;
  logic [QW-1:0]                   q_ext;
  logic [QW-1:0]                   rt_ext;
  logic [RUNTIME_BITS-1:0]         new_rt;
  logic [TICKET_BITS-1:0]          new_tk;
  logic                            new_fin;
  logic                            accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // slot number folded into the table
  always_comb begin
    slot_mod = '0;
    for (int j = 0; j < SLOT_IN_RANGE; j++) begin
      if (in_slot == lts_pkg::SLOT_FW'(j)) slot_mod = SLOT_W'(j % MAX_TASKS);
    end
  end

  assign load_rt = RUNTIME_BITS'(in_rt);
  assign load_tk = (load_rt == '0) ? '0 : TICKET_BITS'(in_tk);

  assign act_ext  = LIM_W'(active_r);
  assign act_last = (act_ext >= LIM_W'(MAX_TASKS)) ? SLOT_LAST : SLOT_W'(act_ext - 1'b1);

  assign rd_rt = rd_vld_r ? rd_data_r[ENT_W-1:TICKET_BITS] : '0;
  assign rd_tk = rd_vld_r ? rd_data_r[TICKET_BITS-1:0] : '0;

  assign run_sum = run_r + CW'(rd_tk);
  assign hit     = (CW'(draw_r) <= run_sum) && (rd_rt != '0);

  // quantum deduction for the winner
  assign q_ext  = QW'(quantum_r);
  assign rt_ext = QW'(win_rt_r);
  always_comb begin
    new_rt  = win_rt_r;
    new_tk  = win_tk_r;
    new_fin = 1'b0;
    if (quantum_r == '0) begin
      new_rt = win_rt_r;
    end else if (q_ext >= rt_ext) begin
      new_rt  = '0;
      new_tk  = '0;
      new_fin = 1'b1;
    end else begin
      new_rt = RUNTIME_BITS'(rt_ext - q_ext);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    ld_slot_nxt   = ld_slot_r;
    ld_rt_nxt     = ld_rt_r;
    ld_tk_nxt     = ld_tk_r;
    draw_nxt      = draw_r;
    last_nxt      = last_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    run_nxt       = run_r;
    win_rt_nxt    = win_rt_r;
    win_tk_nxt    = win_tk_r;
    win_slot_nxt  = win_slot_r;
    res_found_nxt = res_found_r;
    res_slot_nxt  = res_slot_r;
    res_left_nxt  = res_left_r;
    res_fin_nxt   = res_fin_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    rd_addr       = '0;
    mem_we        = 1'b0;
    mem_wa        = ld_slot_r;
    mem_wd        = {ld_rt_r, ld_tk_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_found_nxt = 1'b0;
          res_slot_nxt  = '0;
          res_left_nxt  = '0;
          res_fin_nxt   = 1'b0;
          if (in_tuser == lts_pkg::REQ_LOAD) begin
            rd_addr     = slot_mod;
            ld_slot_nxt = slot_mod;
            ld_rt_nxt   = load_rt;
            ld_tk_nxt   = load_tk;
            state_nxt   = S_LOAD;
          end else begin
            rd_addr      = '0;
            draw_nxt     = in_draw;
            last_nxt     = act_last;
            scan_idx_nxt = SLOT_W'(1);
            chk_idx_nxt  = '0;
            run_nxt      = '0;
            state_nxt    = (active_r == '0) ? S_FIN : S_SCAN;
          end
        end
      end
      S_LOAD: begin
        // old tickets of the slot leave the total, new ones enter
        mem_we    = 1'b1;
        total_nxt = total_r - lts_pkg::TOTAL_W'(rd_tk) + lts_pkg::TOTAL_W'(ld_tk_r);
        state_nxt = S_FIN;
      end
      S_SCAN: begin
        // issue next read while checking the slot read last cycle
        rd_addr = scan_idx_r;
        if (scan_idx_r != SLOT_LAST) scan_idx_nxt = scan_idx_r + 1'b1;
        if (hit) begin
          win_rt_nxt   = rd_rt;
          win_tk_nxt   = rd_tk;
          win_slot_nxt = chk_idx_r;
          state_nxt    = S_WB;
        end else if (chk_idx_r == last_r) begin
          state_nxt = S_FIN;
        end else begin
          run_nxt     = run_sum;
          chk_idx_nxt = chk_idx_r + 1'b1;
        end
      end
      S_WB: begin
        mem_we        = 1'b1;
        mem_wa        = win_slot_r;
        mem_wd        = {new_rt, new_tk};
        if (new_fin) total_nxt = total_r - lts_pkg::TOTAL_W'(win_tk_r);
        res_found_nxt = 1'b1;
        res_slot_nxt  = lts_pkg::SLOT_FW'(win_slot_r);
        res_left_nxt  = lts_pkg::RUNTIME_FW'(new_rt);
        res_fin_nxt   = new_fin;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_found_r;
          out_data_nxt  = {6'd0, total_r, (total_r == '0), res_fin_r, res_left_r,
                           res_slot_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantum_r   <= lts_pkg::QUANTUM_RESET;
      active_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          lts_pkg::REG_QUANTUM: quantum_r <= cfg_wdata[lts_pkg::QUANTUM_W-1:0];
          lts_pkg::REG_ACTIVE:  active_r  <= cfg_wdata[lts_pkg::ACTIVE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ld_slot_r   <= ld_slot_nxt;
    ld_rt_r     <= ld_rt_nxt;
    ld_tk_r     <= ld_tk_nxt;
    draw_r      <= draw_nxt;
    last_r      <= last_nxt;
    scan_idx_r  <= scan_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    run_r       <= run_nxt;
    win_rt_r    <= win_rt_nxt;
    win_tk_r    <= win_tk_nxt;
    win_slot_r  <= win_slot_nxt;
    res_found_r <= res_found_nxt;
    res_slot_r  <= res_slot_nxt;
    res_left_r  <= res_left_nxt;
    res_fin_r   <= res_fin_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  // per-slot valid bits: an unwritten slot reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) vld_r[mem_wa] <= 1'b1;
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  `LTS_ASSERT_NOW(a_we_state, mem_we, (state_r == S_LOAD) || (state_r == S_WB), "RAM write outside load or write-back")
  `LTS_ASSERT_NOW(a_scan_bound, state_r == S_SCAN, chk_idx_r <= last_r, "scan ran past the last active slot")
  `LTS_ASSERT_NOW(a_nowin_zero, out_valid_r && !out_user_r, out_data_r[20:0] == '0, "no-winner result carries winner fields")
  `LTS_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second request taken while one is in flight")

endmodule
